// ===== design/skyline_rectangle_packer_assert.svh =====
// assertion macros for the skyline rectangle packer checker
// used by skypk_chk, relies on clk and arst_n in the including scope
`ifndef SKYLINE_RECTANGLE_PACKER_ASSERT_SVH
`define SKYLINE_RECTANGLE_PACKER_ASSERT_SVH

// same-cycle implication
`define SKY_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skyline packer check failed");

// next-cycle implication
`define SKY_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skyline packer check failed");

`endif

// ===== design/skypk_pkg.sv =====
// shared types and codes for the skyline rectangle packer
// no dependencies
package skypk_pkg;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;

	localparam logic [1:0] STAT_PLACED  = 2'd0;
	localparam logic [1:0] STAT_NO_ROOM = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	localparam logic CFG_ATLAS_W = 1'b0;
	localparam logic CFG_MAX_H   = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] top;
		logic [DIM_W-1:0] wid;
	} seg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SGOT,
		ST_JRD,
		ST_JGOT,
		ST_EVAL,
		ST_SEND,
		ST_WRD,
		ST_WGOT,
		ST_WNEW,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// ===== design/skypk_segmem.sv =====
// segment store: one write port, one registered read port
// depends on skypk_pkg
module skypk_segmem #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output skypk_pkg::seg_t          rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  skypk_pkg::seg_t          wr_data
);
	import skypk_pkg::*;

	seg_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/skyline_rectangle_packer.sv =====
// skyline rectangle packer: one rectangle per transfer, bottom-left skyline placement
// a zero-size item is refused straight away; a placement reads each candidate segment and the
// segments it overlaps and keeps the lowest, then rebuilds the skyline into the other bank
// one item at a time: the input stalls while an item is in work
// reset: control cleared, skyline flat at width min(4096,MAX_DIM) in entry zero at first transfer
// depends on skypk_pkg and skypk_segmem
module skyline_rectangle_packer #(
	parameter int MAX_SEGMENTS = 64,
	parameter int MAX_DIM      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        new_atlas,
	input  logic [12:0] rect_w,
	input  logic [12:0] rect_h,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [12:0] used_height
);
	import skypk_pkg::*;

	localparam int IDX_W   = $clog2(MAX_SEGMENTS);
	localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int DEPTH   = 2 * MAX_SEGMENTS;
	localparam int ADDR_W  = IDX_W + 1;
	localparam logic [DIM_W-1:0] RESET_W = DIM_W'((MAX_DIM < 4096) ? MAX_DIM : 4096);
	localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

	state_t state_q, state_nx;

	// configuration registers
	logic [DIM_W-1:0] aw_q, mh_q;

	// skyline bookkeeping
	logic             bank_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0] hused_q;
	logic [DIM_W-1:0] flat_w_q;
	logic             pend_q;

	// item registers
	logic [DIM_W-1:0] rw_q, rh_q;

	// search registers
	logic [CNT_W-1:0] i_q, j_q;
	logic [DIM_W-1:0] x_q, wi_q, maxt_q;
	logic [DIM_W:0]   cov_q;
	logic             found_q;
	logic [CNT_W-1:0] best_i_q;
	logic [DIM_W-1:0] best_x_q, best_y_q;

	// rebuild registers
	logic [CNT_W-1:0] m_q;
	logic [DIM_W-1:0] rem_q, last_top_q, last_w_q;
	logic             new_done_q, ovf_q;

	// result
	logic [1:0]       res_stat_q;
	logic [POS_W-1:0] res_x_q, res_y_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic [DIM_W-1:0] used_q;

	// memory port signals
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              wr_en;
	seg_t              rd_data, wr_data;

	logic             in_xfer, restart;
	logic [DIM_W-1:0] lim, top_new, aw_clamp;
	logic [DIM_W:0]   fit_sum, ybot;
	logic [DIM_W:0]   cov_next;
	logic             m_full;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign restart  = new_atlas || pend_q;

	assign aw_clamp = (32'(aw_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : aw_q;
	assign lim      = (32'(mh_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : mh_q;
	assign fit_sum  = {1'b0, x_q} + {1'b0, rw_q};
	assign ybot     = {1'b0, best_y_q} + {1'b0, rh_q};
	assign top_new  = ybot[DIM_W-1:0];
	assign cov_next = cov_q + {1'b0, rd_data.wid};
	assign m_full   = (m_q >= SEG_MAX);

	skypk_segmem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (rect_w == '0 || rect_h == '0) state_nx = ST_DONE;
					else state_nx = ST_SRD;
				end
			end
			ST_SRD:  state_nx = ST_SGOT;
			ST_SGOT: begin
				if (fit_sum > {1'b0, flat_w_q}) state_nx = ST_SEND;
				else if ((i_q + 1'b1 < cnt_q) && ({1'b0, rd_data.wid} < {1'b0, rw_q}))
					state_nx = ST_JRD;
				else state_nx = ST_EVAL;
			end
			ST_JRD:  state_nx = ST_JGOT;
			ST_JGOT: begin
				if ((j_q + 1'b1 < cnt_q) && (cov_next < {1'b0, rw_q})) state_nx = ST_JRD;
				else state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				if (i_q + 1'b1 < cnt_q) state_nx = ST_SRD;
				else state_nx = ST_SEND;
			end
			ST_SEND: begin
				if (!found_q || ybot > {1'b0, lim}) state_nx = ST_DONE;
				else if (best_i_q == '0) state_nx = ST_WNEW;
				else state_nx = ST_WRD;
			end
			ST_WRD:  state_nx = ST_WGOT;
			ST_WGOT: begin
				if (!new_done_q && (j_q + 1'b1 == best_i_q)) state_nx = ST_WNEW;
				else if (j_q + 1'b1 < cnt_q) state_nx = ST_WRD;
				else state_nx = ST_FIN;
			end
			ST_WNEW: state_nx = ST_WRD;
			ST_FIN:  state_nx = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_addr = {bank_q, IDX_W'(0)};
		wr_en   = 1'b0;
		wr_addr = {!bank_q, m_q[IDX_W-1:0]};
		wr_data = rd_data;
		case (state_q)
			ST_IDLE: begin
				// restart writes the flat segment into the live bank
				wr_en   = in_xfer && restart;
				wr_addr = {bank_q, IDX_W'(0)};
				wr_data = '{top: '0, wid: new_atlas ? aw_clamp : flat_w_q};
			end
			ST_SRD: rd_addr = {bank_q, i_q[IDX_W-1:0]};
			ST_JRD: rd_addr = {bank_q, j_q[IDX_W-1:0]};
			ST_WRD: rd_addr = {bank_q, j_q[IDX_W-1:0]};
			ST_WGOT: begin
				if (!new_done_q || rem_q == '0) begin
					wr_en = !m_full;
				end else if (rd_data.wid > rem_q) begin
					wr_en   = !m_full;
					wr_data = '{top: rd_data.top, wid: rd_data.wid - rem_q};
				end
			end
			ST_WNEW: begin
				if (m_q != '0 && last_top_q == top_new) begin
					// merge with the equal-height left neighbor
					wr_en   = 1'b1;
					wr_addr = {!bank_q, IDX_W'(m_q - 1'b1)};
					wr_data = '{top: last_top_q, wid: last_w_q + rw_q};
				end else begin
					wr_en   = !m_full;
					wr_data = '{top: top_new, wid: rw_q};
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			aw_q        <= 13'd4096;
			mh_q        <= 13'd4096;
			bank_q      <= 1'b0;
			cnt_q       <= CNT_W'(1);
			hused_q     <= '0;
			flat_w_q    <= RESET_W;
			pend_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ATLAS_W: aw_q <= cfg_data;
					CFG_MAX_H:   mh_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && in_xfer && restart) begin
				pend_q  <= 1'b0;
				cnt_q   <= CNT_W'(1);
				hused_q <= '0;
				if (new_atlas) flat_w_q <= aw_clamp;
			end
			if (state_q == ST_FIN && !ovf_q) begin
				bank_q <= !bank_q;
				cnt_q  <= m_q;
				if (top_new > hused_q) hused_q <= top_new;
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rw_q       <= rect_w;
				rh_q       <= rect_h;
				i_q        <= '0;
				x_q        <= '0;
				found_q    <= 1'b0;
				res_stat_q <= STAT_NO_ROOM;
				res_x_q    <= '0;
				res_y_q    <= '0;
			end
			ST_SGOT: begin
				wi_q   <= rd_data.wid;
				maxt_q <= rd_data.top;
				cov_q  <= {1'b0, rd_data.wid};
				j_q    <= i_q + 1'b1;
			end
			ST_JGOT: begin
				if (rd_data.top > maxt_q) maxt_q <= rd_data.top;
				cov_q <= cov_next;
				j_q   <= j_q + 1'b1;
			end
			ST_EVAL: begin
				// first lowest candidate wins
				if (!found_q || maxt_q < best_y_q) begin
					found_q  <= 1'b1;
					best_i_q <= i_q;
					best_x_q <= x_q;
					best_y_q <= maxt_q;
				end
				x_q <= x_q + wi_q;
				i_q <= i_q + 1'b1;
			end
			ST_SEND: begin
				m_q        <= '0;
				j_q        <= '0;
				new_done_q <= 1'b0;
				ovf_q      <= 1'b0;
			end
			ST_WGOT: begin
				j_q <= j_q + 1'b1;
				if (!new_done_q || rem_q == '0) begin
					if (m_full) ovf_q <= 1'b1;
					else m_q <= m_q + 1'b1;
					last_top_q <= rd_data.top;
					last_w_q   <= rd_data.wid;
				end else if (rd_data.wid <= rem_q) begin
					rem_q <= rem_q - rd_data.wid;
				end else begin
					if (m_full) ovf_q <= 1'b1;
					else m_q <= m_q + 1'b1;
					rem_q <= '0;
				end
			end
			ST_WNEW: begin
				new_done_q <= 1'b1;
				rem_q      <= rw_q;
				if (!(m_q != '0 && last_top_q == top_new)) begin
					if (m_full) ovf_q <= 1'b1;
					else m_q <= m_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (ovf_q) begin
					res_stat_q <= STAT_FULL;
				end else begin
					res_stat_q <= STAT_PLACED;
					res_x_q    <= best_x_q[POS_W-1:0];
					res_y_q    <= best_y_q[POS_W-1:0];
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					status_q <= res_stat_q;
					pos_x_q  <= res_x_q;
					pos_y_q  <= res_y_q;
					used_q   <= hused_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign used_height = used_q;

endmodule

// ===== design/skypk_chk.sv =====
// port-level checker for the skyline rectangle packer, bound to the top level
// depends on skyline_rectangle_packer_assert.svh and skypk_pkg
`include "skyline_rectangle_packer_assert.svh"

module skypk_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [12:0] cfg_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic        new_atlas,
	input logic [12:0] rect_w,
	input logic [12:0] rect_h,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [11:0] pos_x,
	input logic [11:0] pos_y,
	input logic [12:0] used_height
);
	import skypk_pkg::*;

	// busy after every input transfer
	`SKY_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)
	// result held while stalled
	`SKY_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// refused items carry a zero corner
	`SKY_ASSERT_NOW(a_zero_pos, out_valid && status != STAT_PLACED,
		pos_x == '0 && pos_y == '0)
	// placed rectangle lies below the used height
	`SKY_ASSERT_NOW(a_used_covers, out_valid && status == STAT_PLACED,
		used_height > {1'b0, pos_y})

endmodule

bind skyline_rectangle_packer skypk_chk u_skypk_chk (.*);

// ===== verif/skyline_rectangle_packer_chk.sv =====
// checker for the skyline rectangle packer: follows both channels and the register port,
// predicts each placement with its own skyline copy and compares the transfers
// depends on skypk_pkg
module skyline_rectangle_packer_chk #(
	parameter int MAX_SEGMENTS = 64,
	parameter int MAX_DIM      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        new_atlas,
	input  logic [12:0] rect_w,
	input  logic [12:0] rect_h,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [12:0] used_height,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import skypk_pkg::*;

	typedef struct packed {
		logic [1:0]       st;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] uh;
	} placement_t;

	placement_t placements_due[$];

	int unsigned atlas_w_reg, max_h_reg;
	int unsigned sky_top[MAX_SEGMENTS];
	int unsigned sky_wid[MAX_SEGMENTS];
	int unsigned sky_cnt, sky_height;
	int unsigned nt[MAX_SEGMENTS+1];
	int unsigned nw[MAX_SEGMENTS+1];

	function automatic int unsigned clamp_dim(int unsigned v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic void flatten_skyline();
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			sky_top[k] = 0;
			sky_wid[k] = 0;
		end
		sky_wid[0] = clamp_dim(atlas_w_reg);
		sky_cnt = 1;
		sky_height = 0;
	endfunction

	function automatic placement_t result_of(logic [1:0] st, int unsigned x, int unsigned y);
		placement_t p;
		p.st = st;
		p.x = x[POS_W-1:0];
		p.y = y[POS_W-1:0];
		p.uh = sky_height[DIM_W-1:0];
		return p;
	endfunction

	// bottom-left placement on the local skyline copy
	function automatic placement_t place_rect(logic na, int unsigned rw, int unsigned rh);
		int unsigned n, total, x, bi, bx, by, cov, lift, y, m, rem, top, i, j;
		bit found;
		total = 0;
		x = 0;
		bi = 0;
		bx = 0;
		by = 0;
		found = 0;
		if (na) flatten_skyline();
		n = (sky_cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : sky_cnt;
		for (i = 0; i < n; i++) total += sky_wid[i];
		if (rw == 0 || rh == 0) return result_of(STAT_NO_ROOM, 0, 0);
		for (i = 0; i < n; i++) begin
			if (x + rw > total) break;
			cov = sky_wid[i];
			lift = 0;
			for (j = i + 1; j < n && cov < rw; j++) begin
				if (sky_top[j] > sky_top[i] && sky_top[j] - sky_top[i] > lift)
					lift = sky_top[j] - sky_top[i];
				cov += sky_wid[j];
			end
			y = sky_top[i] + lift;
			if (!found || y < by) begin
				found = 1;
				bi = i;
				bx = x;
				by = y;
			end
			x += sky_wid[i];
		end
		if (!found || by + rh > clamp_dim(max_h_reg)) return result_of(STAT_NO_ROOM, 0, 0);
		m = 0;
		rem = rw;
		top = by + rh;
		for (j = 0; j < bi; j++) begin
			nt[m] = sky_top[j];
			nw[m] = sky_wid[j];
			m++;
		end
		// merge with an equal-height left neighbor
		if (m > 0 && nt[m-1] == top) begin
			nw[m-1] += rw;
		end else begin
			nt[m] = top;
			nw[m] = rw;
			m++;
		end
		for (j = bi; j < n && rem > 0; j++) begin
			if (sky_wid[j] <= rem) begin
				rem -= sky_wid[j];
			end else begin
				nt[m] = sky_top[j];
				nw[m] = sky_wid[j] - rem;
				m++;
				rem = 0;
			end
		end
		for (; j < n; j++) begin
			if (m > MAX_SEGMENTS) break;
			nt[m] = sky_top[j];
			nw[m] = sky_wid[j];
			m++;
		end
		if (m > MAX_SEGMENTS) return result_of(STAT_FULL, 0, 0);
		for (j = 0; j < m; j++) begin
			sky_top[j] = nt[j] & 13'h1fff;
			sky_wid[j] = nw[j] & 13'h1fff;
		end
		sky_cnt = m;
		if (top > sky_height) sky_height = top;
		return result_of(STAT_PLACED, bx, by);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t due;
		if (!arst_n) begin
			atlas_w_reg = MAX_DIM;
			max_h_reg = MAX_DIM;
			flatten_skyline();
			placements_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (placements_due.size() == 0) begin
					$display("%0t: unexpected result transfer st=%0d x=%0d y=%0d uh=%0d",
						$time, status, pos_x, pos_y, used_height);
					fail_count <= fail_count + 1;
				end else begin
					due = placements_due.pop_front();
					if (due.st !== status || due.x !== pos_x || due.y !== pos_y ||
							due.uh !== used_height) begin
						$display("%0t: mismatch expected st=%0d x=%0d y=%0d uh=%0d",
							$time, due.st, due.x, due.y, due.uh);
						$display("%0t:          actual   st=%0d x=%0d y=%0d uh=%0d",
							$time, status, pos_x, pos_y, used_height);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				placements_due = {placements_due, place_rect(new_atlas, rect_w, rect_h)};
			if (cfg_we) begin
				if (cfg_index == CFG_ATLAS_W) atlas_w_reg = cfg_data;
				else max_h_reg = cfg_data;
			end
			pending <= placements_due.size();
		end
	end

endmodule

// ===== verif/skyline_rectangle_packer_tb.sv =====
// testbench top for the skyline rectangle packer: clock, reset, register writes,
// rectangle stimulus with random idling, watchdog and verdict
// depends on skypk_pkg, skyline_rectangle_packer and skyline_rectangle_packer_chk
module skyline_rectangle_packer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skypk_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_ATLAS_W;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        new_atlas = 1'b0;
	logic [12:0] rect_w = 13'd1;
	logic [12:0] rect_h = 13'd1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [12:0] used_height;
	int          fail_count;
	int          pending;

	// idling rates in percent, and a long receiver hold-off on request
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_cycles = 0;
	int unsigned cur_atlas_w = 4096;
	int unsigned quiet_cycles = 0;

	localparam int unsigned WATCHDOG_LIMIT = 200000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	skyline_rectangle_packer u_top (.*);

	skyline_rectangle_packer_chk u_chk (.*);

	// receiver side: one stall decision per falling edge
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_stall <= 1'b1;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// offer one rectangle, after optional idle cycles, and hold it until the transfer
	task automatic send_rect(logic na, logic [12:0] w, logic [12:0] h);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		new_atlas <= na;
		rect_w <= w;
		rect_h <= h;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
	endtask

	// drain: drop valid and wait for every outstanding placement
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register writes happen only with the block idle
	task automatic write_reg(logic idx, logic [12:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ATLAS_W) cur_atlas_w = (val > 4096) ? 4096 : val;
	endtask

	task automatic set_regs(logic [12:0] aw, logic [12:0] mh);
		wait_idle();
		write_reg(CFG_ATLAS_W, aw);
		write_reg(CFG_MAX_H, mh);
	endtask

	// one fresh atlas filled with mostly well-formed rectangles, some noise mixed in
	task automatic pack_atlas(int unsigned count);
		int unsigned wmax, hmax, kind;
		logic [12:0] w, h;
		wmax = (cur_atlas_w < 8) ? 8 : cur_atlas_w / 4;
		hmax = $urandom_range(1, 2) == 1 ? 40 : 400;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(99);
			if (kind < 6) begin
				w = 13'($urandom);
				h = 13'($urandom);
			end else if (kind < 12) begin
				w = 13'($urandom_range(1, 24));
				h = 13'($urandom_range(1, 4096));
			end else begin
				// narrow and uneven so the segment store fills up
				w = 13'($urandom_range(1, (kind < 60) ? 12 : wmax));
				h = 13'($urandom_range(1, hmax));
			end
			send_rect(k == 0 || $urandom_range(99) == 0, w, h);
		end
	endtask

	task automatic run_phase(int unsigned items);
		int unsigned sent;
		sent = 0;
		while (sent < items) begin
			int unsigned cnt;
			cnt = $urandom_range(20, 90);
			case ($urandom_range(5))
				0: set_regs(13'd4096, 13'd4096);
				1: set_regs(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
				2: set_regs(13'($urandom_range(4097, 8191)), 13'($urandom_range(50, 600)));
				3: set_regs(13'($urandom_range(64, 600)), 13'($urandom_range(4097, 8191)));
				4: set_regs(13'd1, 13'd4096);
				default: set_regs(13'($urandom_range(200, 4096)), 13'd1);
			endcase
			pack_atlas(cnt);
			sent += cnt;
		end
	endtask

	initial begin
		int unsigned drain_wait;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// directed: reset skyline, zero sizes, extremes, too wide and too tall
		send_rect(1'b0, 13'd4096, 13'd1);
		send_rect(1'b0, 13'd1, 13'd1);
		send_rect(1'b1, 13'd0, 13'd5);
		send_rect(1'b0, 13'd7, 13'd0);
		send_rect(1'b1, 13'd4096, 13'd4096);
		send_rect(1'b0, 13'd1, 13'd1);
		send_rect(1'b1, 13'd8191, 13'd8191);
		send_rect(1'b1, 13'd4097, 13'd1);
		send_rect(1'b0, 13'd100, 13'd4097);
		send_rect(1'b1, 13'd100, 13'd50);
		send_rect(1'b0, 13'd100, 13'd50);
		send_rect(1'b0, 13'd50, 13'd20);
		send_rect(1'b0, 13'd300, 13'd10);
		send_rect(1'b0, 13'd3000, 13'd4040);
		// zero width and zero height registers refuse everything
		set_regs(13'd0, 13'd4096);
		send_rect(1'b1, 13'd1, 13'd1);
		set_regs(13'd64, 13'd0);
		send_rect(1'b1, 13'd1, 13'd1);
		set_regs(13'd8191, 13'd8191);
		send_rect(1'b1, 13'd4096, 13'd4096);
		send_rect(1'b0, 13'd1, 13'd1);
		set_regs(13'd1, 13'd1);
		send_rect(1'b1, 13'd1, 13'd1);
		send_rect(1'b0, 13'd1, 13'd1);

		// long receiver hold-off while the sender keeps offering
		set_regs(13'd4096, 13'd4096);
		rx_hold_cycles = 400;
		pack_atlas(30);

		tx_idle_pct = 12;
		rx_idle_pct = 49;
		run_phase(330);
		tx_idle_pct = 49;
		rx_idle_pct = 12;
		run_phase(330);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(340);

		@(negedge clk);
		in_valid <= 1'b0;
		drain_wait = 0;
		while (pending != 0 && drain_wait < WATCHDOG_LIMIT) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
